/* rtl/core/refcounted_rescale_table_cache_macros.svh */
// Assertion macros shared by the checker of the rescale table cache.
`ifndef REFCOUNTED_RESCALE_TABLE_CACHE_MACROS_SVH
`define REFCOUNTED_RESCALE_TABLE_CACHE_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define RRTC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define RRTC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define RRTC_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/rrtc_pkg.sv */
// Shared types, widths and codes of the rescale table cache.
package rrtc_pkg;

    localparam int DEF_NUM_SLOTS = 8;
    localparam int TABLE_LEN     = 256;
    localparam int TABLE_AW      = 8;

    localparam int ACTION_W      = 2;
    localparam int GAIN_W        = 24;
    localparam int OFFSET_W      = 24;
    localparam int SLOT_FIELD_W  = 3;
    localparam int INDEX_W       = 8;
    localparam int STATUS_W      = 2;
    localparam int VALUE_W       = 8;
    localparam int KIND_W        = 2;

    localparam logic [ACTION_W-1:0] ACT_ACQUIRE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ    = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_HIT    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FILLED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd3;

    // Work kinds after decode; out-of-range release/read collapse into no-op.
    localparam logic [KIND_W-1:0] KIND_ACQUIRE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NOP     = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [GAIN_W-1:0]       gain;
        logic [OFFSET_W-1:0]     offset;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [INDEX_W-1:0]      index;
    } item_t;

endpackage

/* rtl/core/refcounted_rescale_table_cache.sv */
// Top level of the reference-counted rescale table cache.
//
// A cache of NUM_SLOTS byte rescale tables of 256 entries each, tagged by a
// signed Q7.16 gain and a signed Q15.8 offset, with an 8-bit saturating
// reference count per slot. Every input beat (acquire, release, read) gives
// exactly one result beat. Acquire returns a hit on the lowest valid slot with
// a matching tag (one more reference), otherwise fills the lowest never-filled
// slot, or failing that the lowest filled slot with no references, with
// round(gain*j + offset) clamped to 0..255 for j = 0..255 and gives it one
// reference; with no usable slot it reports full and changes nothing. Release
// drops one reference (never below zero); read returns one table byte, or
// zero for an unfilled or out-of-range slot. Timing: a front end decodes
// beats into a two-entry queue, so input beats are taken while the back end
// works and while a result waits, as long as the queue has room. The back
// end handles one item at a time: a hit, release or unused code goes from the
// queue through the idle, execute and done states to the result register,
// a read adds a read state for the registered table memory read, and an
// acquire miss a fill loop writing one table byte per cycle through the
// single write port of the table memory. The table memory has no reset and
// no clearing pass: a slot is read only after all of its bytes are written.
module refcounted_rescale_table_cache
    import rrtc_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [ACTION_W-1:0]        s_action,
    input  logic signed [GAIN_W-1:0]   s_gain,
    input  logic signed [OFFSET_W-1:0] s_offset,
    input  logic [SLOT_FIELD_W-1:0]    s_slot,
    input  logic [INDEX_W-1:0]         s_index,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [STATUS_W-1:0]        m_status,
    output logic [SLOT_FIELD_W-1:0]    m_slot_out,
    output logic [VALUE_W-1:0]         m_value
);

    // Queue between the decoder and the execution engine.
    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    // Decode and queue input beats; out-of-range slots become no-ops here.
    rrtc_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .s_gain   (s_gain),
        .s_offset (s_offset),
        .s_slot   (s_slot),
        .s_index  (s_index),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // Search tags, update counts, fill tables and hold the result beat.
    rrtc_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_slot_out (m_slot_out),
        .m_value    (m_value)
    );

endmodule

/* rtl/core/rrtc_front.sv */
// Front end: accepts input beats, decodes them and queues them for the back end.
module rrtc_front
    import rrtc_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [ACTION_W-1:0]        s_action,
    input  logic signed [GAIN_W-1:0]   s_gain,
    input  logic signed [OFFSET_W-1:0] s_offset,
    input  logic [SLOT_FIELD_W-1:0]    s_slot,
    input  logic [INDEX_W-1:0]         s_index,
    output logic                       q_valid,
    output item_t                      q_item,
    input  logic                       q_pop
);

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    item_t             q_mem_reg [QDEPTH];
    logic [QAW-1:0]    wr_ptr_reg;
    logic [QAW-1:0]    rd_ptr_reg;
    logic [QAW:0]      count_reg;
    logic              push;
    logic              slot_ok;
    logic [KIND_W-1:0] kind;
    item_t             item_in;

    assign slot_ok = (int'(s_slot) < NUM_SLOTS);

    always_comb begin
        unique case (s_action)
            ACT_ACQUIRE: kind = KIND_ACQUIRE;
            ACT_RELEASE: kind = slot_ok ? KIND_RELEASE : KIND_NOP;
            ACT_READ:    kind = slot_ok ? KIND_READ : KIND_NOP;
            default:     kind = KIND_NOP;
        endcase
    end

    always_comb begin
        item_in.kind   = kind;
        item_in.gain   = s_gain;
        item_in.offset = s_offset;
        item_in.slot   = s_slot;
        item_in.index  = s_index;
    end

    assign s_ready = (count_reg != (QAW+1)'(QDEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_item  = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (q_pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

/* rtl/core/rrtc_back.sv */
// Back end: slot search, reference counts, table fill, table memory and result register.
module rrtc_back
    import rrtc_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_valid,
    input  item_t                   q_item,
    output logic                    q_pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [STATUS_W-1:0]     m_status,
    output logic [SLOT_FIELD_W-1:0] m_slot_out,
    output logic [VALUE_W-1:0]      m_value
);

    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int MEM_DEPTH = NUM_SLOTS * TABLE_LEN;
    localparam int MEM_AW    = SLOT_W + TABLE_AW;
    localparam int REF_W     = 8;
    localparam int ACC_W     = 34;
    localparam int FRAC      = 16;
    localparam int OFF_SHIFT = 8;
    localparam int ROUND_BIAS = 32768;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_FILL = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    item_t                   item_reg;
    logic [NUM_SLOTS-1:0]    valid_reg;
    logic [GAIN_W-1:0]       tag_gain_reg   [NUM_SLOTS];
    logic [OFFSET_W-1:0]     tag_offset_reg [NUM_SLOTS];
    logic [REF_W-1:0]        ref_reg        [NUM_SLOTS];
    logic signed [ACC_W-1:0] acc_reg;
    logic [TABLE_AW-1:0]     fill_idx_reg;
    logic [SLOT_W-1:0]       fill_slot_reg;
    logic [STATUS_W-1:0]     res_status_reg;
    logic [SLOT_FIELD_W-1:0] res_slot_reg;
    logic [VALUE_W-1:0]      res_value_reg;
    logic                    m_valid_reg;
    logic [STATUS_W-1:0]     m_status_reg;
    logic [SLOT_FIELD_W-1:0] m_slot_reg;
    logic [VALUE_W-1:0]      m_value_reg;
    logic [VALUE_W-1:0]      mem [MEM_DEPTH];
    logic [VALUE_W-1:0]      rd_data_reg;

    logic                    hit_found;
    logic [SLOT_W-1:0]       hit_idx;
    logic                    empty_found;
    logic [SLOT_W-1:0]       empty_idx;
    logic                    free_found;
    logic [SLOT_W-1:0]       free_idx;
    logic                    pick_found;
    logic [SLOT_W-1:0]       pick_idx;
    logic [SLOT_W-1:0]       item_slot;
    logic                    is_acq;
    logic                    do_hit;
    logic                    do_start;
    logic                    do_release;
    logic                    fill_last;
    logic                    load_out;
    logic signed [ACC_W-1:0] gain_ext;
    logic signed [ACC_W-1:0] acc_init;
    logic [VALUE_W-1:0]      entry;
    logic [MEM_AW-1:0]       rd_addr;

    assign item_slot = SLOT_W'(item_reg.slot);
    assign gain_ext  = ACC_W'($signed(item_reg.gain));
    assign acc_init  = (ACC_W'($signed(item_reg.offset)) <<< OFF_SHIFT)
                     + ACC_W'(ROUND_BIAS);
    assign rd_addr   = {item_slot, item_reg.index};

    // Priority search: lowest matching valid slot, lowest empty, lowest idle.
    always_comb begin
        hit_found   = 1'b0;
        hit_idx     = '0;
        empty_found = 1'b0;
        empty_idx   = '0;
        free_found  = 1'b0;
        free_idx    = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (valid_reg[i] && tag_gain_reg[i] == item_reg.gain
                    && tag_offset_reg[i] == item_reg.offset) begin
                hit_found = 1'b1;
                hit_idx   = SLOT_W'(i);
            end
            if (!valid_reg[i]) begin
                empty_found = 1'b1;
                empty_idx   = SLOT_W'(i);
            end
            if (valid_reg[i] && ref_reg[i] == '0) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign pick_found = empty_found || free_found;
    assign pick_idx   = empty_found ? empty_idx : free_idx;

    assign is_acq     = (state_reg == ST_EXEC) && (item_reg.kind == KIND_ACQUIRE);
    assign do_hit     = is_acq && hit_found;
    assign do_start   = is_acq && !hit_found && pick_found;
    assign do_release = (state_reg == ST_EXEC) && (item_reg.kind == KIND_RELEASE);
    assign fill_last  = (state_reg == ST_FILL) && (fill_idx_reg == TABLE_AW'(TABLE_LEN - 1));

    // Clamp the rounded Q16 sum to one byte.
    always_comb begin
        if (acc_reg[ACC_W-1]) begin
            entry = '0;
        end else if (|acc_reg[ACC_W-2:FRAC+VALUE_W]) begin
            entry = '1;
        end else begin
            entry = acc_reg[FRAC+VALUE_W-1:FRAC];
        end
    end

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (item_reg.kind)
                    KIND_ACQUIRE: state_next = do_start ? ST_FILL : ST_DONE;
                    KIND_READ:    state_next = ST_READ;
                    default:      state_next = ST_DONE;
                endcase
            end
            ST_FILL: begin
                if (fill_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_READ: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                ref_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (fill_last) begin
                valid_reg[fill_slot_reg] <= 1'b1;
            end
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (do_hit && hit_idx == SLOT_W'(i) && ref_reg[i] != '1) begin
                    ref_reg[i] <= ref_reg[i] + 1'b1;
                end else if (do_release && item_slot == SLOT_W'(i) && ref_reg[i] != '0) begin
                    ref_reg[i] <= ref_reg[i] - 1'b1;
                end else if (fill_last && fill_slot_reg == SLOT_W'(i)) begin
                    ref_reg[i] <= REF_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_item;
        end
        if (do_start) begin
            acc_reg       <= acc_init;
            fill_idx_reg  <= '0;
            fill_slot_reg <= pick_idx;
        end else if (state_reg == ST_FILL) begin
            acc_reg      <= acc_reg + gain_ext;
            fill_idx_reg <= fill_idx_reg + 1'b1;
        end
        if (fill_last) begin
            tag_gain_reg[fill_slot_reg]   <= item_reg.gain;
            tag_offset_reg[fill_slot_reg] <= item_reg.offset;
        end
        if (state_reg == ST_EXEC) begin
            res_value_reg <= '0;
            case (item_reg.kind)
                KIND_ACQUIRE: begin
                    if (hit_found) begin
                        res_status_reg <= STAT_HIT;
                        res_slot_reg   <= SLOT_FIELD_W'(hit_idx);
                    end else if (pick_found) begin
                        res_status_reg <= STAT_FILLED;
                        res_slot_reg   <= SLOT_FIELD_W'(pick_idx);
                    end else begin
                        res_status_reg <= STAT_FULL;
                        res_slot_reg   <= '0;
                    end
                end
                default: begin
                    res_status_reg <= STAT_DONE;
                    res_slot_reg   <= '0;
                end
            endcase
        end
        if (state_reg == ST_READ) begin
            res_value_reg <= valid_reg[item_slot] ? rd_data_reg : '0;
        end
        if (load_out) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
            m_value_reg  <= res_value_reg;
        end
    end

    // Table memory: one write port for the fill, one registered read port.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FILL) begin
            mem[{fill_slot_reg, fill_idx_reg}] <= entry;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_slot_out = m_slot_reg;
    assign m_value    = m_value_reg;

endmodule

/* rtl/core/rrtc_checker.sv */
// Port-level checker of the rescale table cache and its bind to the top level.
`include "refcounted_rescale_table_cache_macros.svh"

module rrtc_checker
    import rrtc_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [STATUS_W-1:0]     m_status,
    input logic [SLOT_FIELD_W-1:0] m_slot_out,
    input logic [VALUE_W-1:0]      m_value
);

    // Reset must drop any pending result beat.
    `RRTC_ASSERT_RST(a_reset_clears_out, !aresetn, !m_valid, "result valid after reset")

    // A stalled result beat holds.
    `RRTC_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_slot_out) && $stable(m_value), "stalled result changed")

    // A full report grants no slot and carries no byte.
    `RRTC_ASSERT_IMP(a_full_clean, m_valid && m_status == STAT_FULL, m_slot_out == '0 && m_value == '0, "full result not clean")

    // Only a read can return a nonzero byte.
    `RRTC_ASSERT_IMP(a_value_only_read, m_valid && m_value != '0, m_status == STAT_DONE && m_slot_out == '0, "byte on non-read result")

endmodule

bind refcounted_rescale_table_cache rrtc_checker u_rrtc_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_status   (m_status),
    .m_slot_out (m_slot_out),
    .m_value    (m_value)
);
